[hdl/rmsp_pkg.sv]
package rmsp_pkg;

	// Item as it moves down the update pipeline
	typedef struct packed {
		logic               vld;
		logic [11:0]        idx;
		logic signed [15:0] w;
		logic               neg;
		logic [15:0]        gmag;
		logic               skip;
	} rmsp_item_t;

	// Decay weights in Q0.16; they sum to exactly one
	localparam logic [15:0] COEF_KEEP = 16'd58982;
	localparam logic [15:0] COEF_NEW  = 16'd6554;
	localparam logic [15:0] ROUND_HALF = 16'd32768;

	localparam logic [15:0] LR_RESET = 16'd66;

	localparam int unsigned MS_W    = 32;
	localparam int unsigned ROOT_W  = 24;
	localparam int unsigned Q_W     = 17;
	localparam int unsigned DIV_W   = ROOT_W + Q_W;

endpackage

[hdl/rmsprop_weight_update.sv]
// RMSprop update of one weight per item.
// Input stream s_axis: one item per weight, tdata carries the weight index,
// the current weight and its gradient (signed Q3.12). Output stream m_axis:
// one item per input item, in order, with the echoed index and the new
// weight in tdata and the skip flag in tuser.
// cfg_we/cfg_wdata write the Q0.16 learning rate; write it only while idle.
// Throughput is one item per cycle unless the receiver stalls or the store
// sweep runs, also for repeated indices: the mean square store reads at
// accept, updates and writes back as the item leaves the first store
// register, and a one-entry bypass covers a repeat on the next item.
// Accepted items pass the store registers, the bit-serial square root
// pipeline, the divider pipeline and the output register to m_axis_tvalid.
// After reset the learning rate is 66 and the store is swept to zero, one
// entry a cycle, with s_axis_tready low until every entry is clear.
// When the receiver stalls with a result held, the whole pipeline holds and
// s_axis_tready drops; the result stays in place until taken.
module rmsprop_weight_update #(
	parameter int unsigned WEIGHT_COUNT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// weight_index[11:0], weight_value[27:12], gradient[43:28], zero fill
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_index[11:0], updated_weight[27:12], zero fill
	output logic [31:0] m_axis_tdata,
	// update_skipped[0]
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic                 adv;
	logic                 busy;
	logic [15:0]          lr_q;
	logic [15:0]          grad;
	rmsp_pkg::rmsp_item_t item_in;
	rmsp_pkg::rmsp_item_t ms_item;
	logic [31:0]          ms_val;
	rmsp_pkg::rmsp_item_t sq_item;
	logic [23:0]          sq_root;
	rmsp_pkg::rmsp_item_t dv_item;
	logic signed [15:0]   dv_weight;
	logic                 out_vld_q;
	logic [31:0]          out_data_q;
	logic                 out_skip_q;

	// Advance whenever the output slot is free or being drained
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv && !busy;

	// Unpack the input item
	assign grad = s_axis_tdata[43:28];
	always_comb begin
		item_in.vld  = s_axis_tvalid && s_axis_tready;
		item_in.idx  = s_axis_tdata[11:0];
		item_in.w    = s_axis_tdata[27:12];
		item_in.neg  = grad[15];
		item_in.gmag = grad[15] ? 16'(~grad + 16'd1) : grad;
		item_in.skip = 1'b0;
	end

	// Hold the learning rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= rmsp_pkg::LR_RESET;
		end else if (cfg_we) begin
			lr_q <= cfg_wdata;
		end
	end

	rmsp_ms_store #(
		.WEIGHT_COUNT(WEIGHT_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_in (item_in),
		.item_out(ms_item),
		.ms_out  (ms_val),
		.busy    (busy)
	);

	rmsp_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_in (ms_item),
		.ms_in   (ms_val),
		.item_out(sq_item),
		.root_out(sq_root)
	);

	rmsp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.lr        (lr_q),
		.item_in   (sq_item),
		.root_in   (sq_root),
		.item_out  (dv_item),
		.weight_out(dv_weight)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q  <= dv_item.vld;
			out_data_q <= {4'b0, dv_weight, dv_item.idx};
			out_skip_q <= dv_item.skip;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_skip_q;

endmodule

[hdl/rmsp_ms_store.sv]
module rmsp_ms_store #(
	parameter int unsigned WEIGHT_COUNT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  rmsp_pkg::rmsp_item_t item_in,
	output rmsp_pkg::rmsp_item_t item_out,
	output logic [31:0]          ms_out,
	output logic                 busy
);

	localparam int unsigned AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
	localparam int unsigned RECIP = (33554432 + WEIGHT_COUNT - 1) / WEIGHT_COUNT;
	localparam bit DIRECT = (WEIGHT_COUNT >= 4096);

	logic [31:0]          mem [WEIGHT_COUNT];
	logic [37:0]          idx_prod;
	logic [11:0]          idx_quot;
	logic [11:0]          idx_rem;
	logic [AW-1:0]        rd_slot;
	rmsp_pkg::rmsp_item_t item_s1;
	logic [AW-1:0]        slot_s1;
	logic [30:0]          g2_s1;
	logic [31:0]          rd_q;
	logic                 fwd_vld_q;
	logic [AW-1:0]        fwd_slot_q;
	logic [31:0]          fwd_ms_q;
	logic [31:0]          ms_old;
	logic [48:0]          acc;
	logic [31:0]          ms_new;
	logic                 busy_q;
	logic [AW-1:0]        clr_q;
	rmsp_pkg::rmsp_item_t item_s2;
	logic [31:0]          ms_s2;

	// Fold the index into the store by reciprocal multiply
	assign idx_prod = 38'(item_in.idx) * 38'(RECIP);
	assign idx_quot = idx_prod[36:25];
	assign idx_rem  = item_in.idx - 12'(idx_quot * 12'(WEIGHT_COUNT));
	assign rd_slot  = DIRECT ? AW'(item_in.idx) : AW'(idx_rem);

	// Take the previous item's result when it hits the same entry
	assign ms_old = (fwd_vld_q && (fwd_slot_q == slot_s1)) ? fwd_ms_q : rd_q;
	assign acc = 49'(ms_old) * 49'(rmsp_pkg::COEF_KEEP)
		+ 49'(g2_s1) * 49'(rmsp_pkg::COEF_NEW) + 49'(rmsp_pkg::ROUND_HALF);
	assign ms_new = acc[48] ? '1 : acc[47:16];

	// Clear the store after reset, then write back updates and read ahead
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (adv && item_s1.vld) begin
			mem[slot_s1] <= ms_new;
		end
		if (adv) begin
			rd_q <= mem[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_q      <= '0;
			item_s1    <= '0;
			item_s2    <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(WEIGHT_COUNT - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				item_s1    <= item_in;
				slot_s1    <= rd_slot;
				g2_s1      <= 31'(32'(item_in.gmag) * 32'(item_in.gmag));
				fwd_vld_q  <= item_s1.vld;
				fwd_slot_q <= slot_s1;
				fwd_ms_q   <= ms_new;
				item_s2    <= item_s1;
				ms_s2      <= ms_new;
			end
		end
	end

	assign item_out = item_s2;
	assign ms_out   = ms_s2;
	assign busy     = busy_q;

endmodule

[hdl/rmsp_sqrt.sv]
module rmsp_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  rmsp_pkg::rmsp_item_t item_in,
	input  logic [31:0]          ms_in,
	output rmsp_pkg::rmsp_item_t item_out,
	output logic [23:0]          root_out
);

	localparam int unsigned STEPS = rmsp_pkg::ROOT_W;

	rmsp_pkg::rmsp_item_t item_p [STEPS+1];
	logic [31:0]          ms_p   [STEPS+1];
	logic [25:0]          rem_p  [STEPS+1];
	logic [23:0]          root_p [STEPS+1];

	// Flag a zero mean square at entry
	always_comb begin
		item_p[0]      = item_in;
		item_p[0].skip = (ms_in == '0);
	end
	assign ms_p[0]   = ms_in;
	assign rem_p[0]  = '0;
	assign root_p[0] = '0;

	// One root bit per stage over ms << 16
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int HI = 47 - 2 * k;
		logic [47:0] x;
		logic [27:0] rsh;
		logic [27:0] trial;

		assign x     = {ms_p[k], 16'b0};
		assign rsh   = {rem_p[k], x[HI -: 2]};
		assign trial = {2'b00, root_p[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				item_p[k+1] <= '0;
			end else if (adv) begin
				item_p[k+1] <= item_p[k];
				ms_p[k+1]   <= ms_p[k];
				if (rsh >= trial) begin
					rem_p[k+1]  <= 26'(rsh - trial);
					root_p[k+1] <= {root_p[k][22:0], 1'b1};
				end else begin
					rem_p[k+1]  <= rsh[25:0];
					root_p[k+1] <= {root_p[k][22:0], 1'b0};
				end
			end
		end
	end

	assign item_out = item_p[STEPS];
	assign root_out = root_p[STEPS];

endmodule

[hdl/rmsp_div.sv]
module rmsp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [15:0]          lr,
	input  rmsp_pkg::rmsp_item_t item_in,
	input  logic [23:0]          root_in,
	output rmsp_pkg::rmsp_item_t item_out,
	output logic signed [15:0]   weight_out
);

	localparam int unsigned QW = rmsp_pkg::Q_W;
	localparam int unsigned DW = rmsp_pkg::DIV_W;

	logic [31:0]          lr_prod;
	logic [36:0]          dsum;
	logic                 ovf;
	rmsp_pkg::rmsp_item_t item_p [QW+1];
	logic [DW-1:0]        rem_p  [QW+1];
	logic [QW-1:0]        q_p    [QW+1];
	logic [23:0]          r_p    [QW+1];
	logic                 ovf_p  [QW+1];
	logic [17:0]          delta;
	logic signed [18:0]   wide;

	// Rounded dividend; a quotient past 17 bits saturates anyway
	assign lr_prod = lr * item_in.gmag;
	assign dsum    = 37'({lr_prod, 4'b0}) + 37'(root_in >> 1);
	assign ovf     = DW'(dsum) >= {root_in, QW'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_p[0] <= '0;
		end else if (adv) begin
			item_p[0] <= item_in;
			rem_p[0]  <= DW'(dsum);
			q_p[0]    <= '0;
			r_p[0]    <= root_in;
			ovf_p[0]  <= ovf;
		end
	end

	// One quotient bit per stage, restoring
	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int SH = QW - 1 - j;
		logic [DW-1:0] sub;

		assign sub = DW'(r_p[j]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				item_p[j+1] <= '0;
			end else if (adv) begin
				item_p[j+1] <= item_p[j];
				r_p[j+1]    <= r_p[j];
				ovf_p[j+1]  <= ovf_p[j];
				if (rem_p[j] >= sub) begin
					rem_p[j+1] <= rem_p[j] - sub;
					q_p[j+1]   <= {q_p[j][QW-2:0], 1'b1};
				end else begin
					rem_p[j+1] <= rem_p[j];
					q_p[j+1]   <= {q_p[j][QW-2:0], 1'b0};
				end
			end
		end
	end

	// Apply the step with sign and saturate; a skipped item keeps its weight
	assign delta = ovf_p[QW] ? 18'h20000 : {1'b0, q_p[QW]};
	assign wide  = item_p[QW].neg
		? 19'(item_p[QW].w) + $signed({1'b0, delta})
		: 19'(item_p[QW].w) - $signed({1'b0, delta});

	always_comb begin
		if (item_p[QW].skip) begin
			weight_out = item_p[QW].w;
		end else if (wide > 19'sd32767) begin
			weight_out = 16'sh7fff;
		end else if (wide < -19'sd32768) begin
			weight_out = -16'sh8000;
		end else begin
			weight_out = wide[15:0];
		end
	end

	assign item_out = item_p[QW];

endmodule

[hdl/rmsp_checker.sv]
module rmsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output item changed");

	// A full, stalled output blocks new items
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// The store sweep keeps the input closed right after reset
	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_axis_tready && !m_axis_tvalid)
		else $error("input open during store sweep");

endmodule

bind rmsprop_weight_update rmsp_checker u_rmsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

[test/tb_rmsprop_weight_update.sv]
module tb_rmsprop_weight_update;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STORE_DEPTH = 4096;
	localparam int unsigned PIPE_LATENCY = 45;
	localparam logic [15:0] LR_MAX = 16'hFFFF;

	typedef struct packed {
		logic [11:0]        idx;
		logic signed [15:0] weight;
		logic               skipped;
	} weight_result_t;

	typedef struct {
		logic [11:0]        idx;
		logic signed [15:0] weight;
		logic signed [15:0] grad;
		logic               check_fixed;
		weight_result_t     fixed;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// shadow state of the block
	logic [31:0] ms_shadow [STORE_DEPTH];
	logic [15:0] lr_shadow;

	weight_result_t pending_results[$];
	int  error_count = 0;
	bit  quiet_tail = 1'b0;
	bit  hold_off = 1'b0;

	rmsprop_weight_update dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] int_sqrt(input logic [47:0] v);
		logic [47:0] rem;
		logic [47:0] root;
		logic [47:0] bitv;
		rem = v;
		root = '0;
		bitv = 48'h1 << 46;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root[31:0];
	endfunction

	// advance the mean square of one weight and compute its new value
	function automatic weight_result_t rmsprop_step(input logic [11:0] idx,
			input logic signed [15:0] w, input logic signed [15:0] g);
		weight_result_t res;
		logic [16:0] gmag;
		logic [63:0] acc;
		logic [31:0] ms;
		logic [31:0] root;
		logic [63:0] num;
		logic [63:0] quot;
		longint nw;
		gmag = g[15] ? 17'(-$signed({g[15], g})) : {1'b0, g};
		acc = 64'(ms_shadow[idx]) * 64'(rmsp_pkg::COEF_KEEP)
			+ 64'(gmag) * 64'(gmag) * 64'(rmsp_pkg::COEF_NEW)
			+ 64'(rmsp_pkg::ROUND_HALF);
		ms = acc[47:16];
		ms_shadow[idx] = ms;
		root = int_sqrt({ms, 16'h0});
		res.idx = idx;
		res.weight = w;
		res.skipped = 1'b0;
		if (root == 0) begin
			res.skipped = 1'b1;
		end else begin
			num = 64'(lr_shadow) * 64'(gmag) * 64'd16;
			quot = (num + 64'(root >> 1)) / 64'(root);
			nw = longint'(w) - (g[15] ? -longint'(quot) : longint'(quot));
			if (nw > 32767) nw = 32767;
			if (nw < -32768) nw = -32768;
			res.weight = 16'(nw);
		end
		return res;
	endfunction

	task automatic send_item(input logic [11:0] idx, input logic signed [15:0] w,
			input logic signed [15:0] g, input bit use_fixed, input weight_result_t fixed);
		weight_result_t predicted;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'h0, g, w, idx};
		predicted = rmsprop_step(idx, w, g);
		if (use_fixed) predicted = fixed;
		pending_results.push_back(predicted);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_rate(input logic [15:0] rate);
		cfg_we <= 1'b1;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we <= 1'b0;
		lr_shadow = rate;
	endtask

	task automatic random_phase(input int count, input int slot_span);
		logic [11:0] idx;
		logic signed [15:0] g;
		for (int i = 0; i < count; i++) begin
			idx = (slot_span == 0) ? 12'($urandom) : 12'($urandom_range(0, slot_span));
			case ($urandom_range(0, 4))
				0: g = 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
				1: g = 16'($signed($urandom_range(0, 64)) - 32);
				2: g = '0;
				default: g = 16'($urandom);
			endcase
			send_item(idx, 16'($urandom), g, 1'b0, '0);
		end
	endtask

	// receiver: random stalls, one long hold-off, compare each result
	initial begin
		weight_result_t want;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with index %0d arrived unexpectedly", m_axis_tdata[11:0]);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tdata[11:0] !== want.idx) begin
						$error("result_index: expected %0d, got %0d", want.idx, m_axis_tdata[11:0]);
						error_count++;
					end
					if (m_axis_tdata[27:12] !== want.weight) begin
						$error("updated_weight: expected %0d, got %0d", want.weight,
							$signed(m_axis_tdata[27:12]));
						error_count++;
					end
					if (m_axis_tuser !== want.skipped) begin
						$error("update_skipped: expected %0d, got %0d", want.skipped, m_axis_tuser);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		stim_row_t directed [$];
		for (int i = 0; i < STORE_DEPTH; i++) ms_shadow[i] = '0;
		lr_shadow = rmsp_pkg::LR_RESET;
		// zero gradient on a fresh entry skips; large values then exercise saturation
		directed = '{
			'{12'd0,    16'sh1234, 16'sh0000, 1'b1, '{12'd0, 16'sh1234, 1'b1}},
			'{12'd4095, 16'sh8000, 16'sh0000, 1'b1, '{12'd4095, 16'sh8000, 1'b1}},
			'{12'd1,    16'sh7FFF, 16'sh7FFF, 1'b0, '0},
			'{12'd2,    16'sh8000, 16'sh8000, 1'b0, '0},
			'{12'd3,    16'sh0000, 16'sh0001, 1'b0, '0},
			'{12'd3,    16'sh0000, 16'shFFFF, 1'b0, '0},
			'{12'd3,    16'sh0000, 16'sh0000, 1'b0, '0},
			'{12'd1,    16'sh7FFF, 16'sh8000, 1'b0, '0},
			'{12'd4095, 16'sh0100, 16'sh0400, 1'b0, '0},
			'{12'd4095, 16'shFF00, 16'shFC00, 1'b0, '0},
			'{12'd2730, 16'sh5555, 16'shAAAA, 1'b0, '0},
			'{12'd1365, 16'shAAAA, 16'sh5555, 1'b0, '0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_item(directed[i].idx, directed[i].weight, directed[i].grad,
				directed[i].check_fixed, directed[i].fixed);
		drain_and_settle();

		// learning-rate extremes with saturation-prone items
		write_rate(LR_MAX);
		random_phase(150, 7);
		drain_and_settle();
		write_rate(16'h0000);
		random_phase(100, 7);
		drain_and_settle();
		write_rate(16'd1000);
		hold_off = 1'b1;
		random_phase(300, 15);
		drain_and_settle();
		write_rate(16'($urandom));
		random_phase(800, 0);
		drain_and_settle();
		write_rate(rmsp_pkg::LR_RESET);
		quiet_tail = 1'b1;
		random_phase(350, 31);

		drain_and_settle();
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

[files.f]
hdl/rmsp_pkg.sv
hdl/rmsp_ms_store.sv
hdl/rmsp_sqrt.sv
hdl/rmsp_div.sv
hdl/rmsprop_weight_update.sv
hdl/rmsp_checker.sv
test/tb_rmsprop_weight_update.sv
